// File: hw/rtl/kmv_pkg.sv
// Package for the keyed running mean / variance unit.
// Shared types, codes and constants; no dependencies.
package kmv_pkg;

   // Default table depth
   localparam int unsigned ENTRIES_DEFAULT = 64;

   // Field widths
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned SLOT_W  = 6;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned VAR_W   = 48;
   localparam int unsigned DEV_W   = 64;
   localparam int unsigned STATS_W = CNT_W + VAL_W + DEV_W;

   // Divider sequencing
   localparam int unsigned DIV_ITER_W = 7;
   localparam logic [DIV_ITER_W-1:0] MEAN_DIV_BITS = DIV_ITER_W'(VAL_W + 1);
   localparam logic [DIV_ITER_W-1:0] VAR_DIV_BITS  = DIV_ITER_W'(DEV_W);

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Result status codes
   typedef enum logic [1:0] {
      ST_UPDATED   = 2'd0,
      ST_NEW_KEY   = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_COUNT_SAT = 2'd3
   } kmv_status_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE, S_KRD, S_KCMP, S_SCAP, S_UPD, S_DIV, S_MEAN, S_AMAG,
      S_MULLO, S_MULHI, S_ACC, S_VSTART, S_VDIV, S_VCAP, S_FIN
   } kmv_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic key_step;
      logic key_new;
      logic key_full;
      logic stat_load;
      logic upd_start;
      logic div_step;
      logic mean_upd;
      logic amag;
      logic mul_lo;
      logic mul_hi;
      logic acc;
      logic var_start;
      logic var_load;
      logic out_load;
   } kmv_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic at_end;
      logic full;
      logic key_match;
      logic cnt_max;
      logic cnt_le1;
      logic div_done;
      logic out_busy;
   } kmv_stat_type;

endpackage

// File: hw/rtl/kmv_if.sv
// Valid/ready channel interfaces for sample requests and results.
// Depends on kmv_pkg.
interface kmv_req_if;
   logic                                valid;
   logic                                ready;
   logic [kmv_pkg::KEY_W-1:0]           key;
   logic signed [kmv_pkg::VAL_W-1:0]    sample_value;

   modport source (output valid, key, sample_value, input ready);
   modport sink   (input valid, key, sample_value, output ready);
endinterface

interface kmv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [kmv_pkg::SLOT_W-1:0]          slot;
   logic [kmv_pkg::CNT_W-1:0]           sample_count;
   logic signed [kmv_pkg::VAL_W-1:0]    running_mean;
   logic [kmv_pkg::VAR_W-1:0]           sample_variance;
   logic [1:0]                          status;

   modport source (output valid, slot, sample_count, running_mean, sample_variance, status,
                   input ready);
   modport sink   (input valid, slot, sample_count, running_mean, sample_variance, status,
                   output ready);
endinterface

// File: hw/rtl/kmv_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module kmv_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

// File: hw/rtl/kmv_ctrl.sv
// Sequencing state machine for the keyed mean / variance unit.
// Depends on kmv_pkg.
module kmv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kmv_pkg::kmv_stat_type st,
   output kmv_pkg::kmv_cmd_type  cmd
);
   kmv_pkg::kmv_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmv_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         kmv_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = kmv_pkg::S_KRD;
            end
         end
         kmv_pkg::S_KRD: begin
            if (st.at_end) begin
               if (st.full) begin
                  cmd.key_full = 1'b1;
                  state_in     = kmv_pkg::S_FIN;
               end else begin
                  cmd.key_new = 1'b1;
                  state_in    = kmv_pkg::S_UPD;
               end
            end else begin
               state_in = kmv_pkg::S_KCMP;
            end
         end
         kmv_pkg::S_KCMP: begin
            if (st.key_match) begin
               state_in = kmv_pkg::S_SCAP;
            end else begin
               cmd.key_step = 1'b1;
               state_in     = kmv_pkg::S_KRD;
            end
         end
         kmv_pkg::S_SCAP: begin
            cmd.stat_load = 1'b1;
            state_in = st.cnt_max ? kmv_pkg::S_VSTART : kmv_pkg::S_UPD;
         end
         kmv_pkg::S_UPD: begin
            cmd.upd_start = 1'b1;
            state_in      = kmv_pkg::S_DIV;
         end
         kmv_pkg::S_DIV: begin
            if (st.div_done) begin
               state_in = kmv_pkg::S_MEAN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         kmv_pkg::S_MEAN: begin
            cmd.mean_upd = 1'b1;
            state_in     = kmv_pkg::S_AMAG;
         end
         kmv_pkg::S_AMAG: begin
            cmd.amag = 1'b1;
            state_in = kmv_pkg::S_MULLO;
         end
         kmv_pkg::S_MULLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = kmv_pkg::S_MULHI;
         end
         kmv_pkg::S_MULHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = kmv_pkg::S_ACC;
         end
         kmv_pkg::S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = kmv_pkg::S_VSTART;
         end
         kmv_pkg::S_VSTART: begin
            cmd.var_start = 1'b1;
            state_in = st.cnt_le1 ? kmv_pkg::S_FIN : kmv_pkg::S_VDIV;
         end
         kmv_pkg::S_VDIV: begin
            if (st.div_done) begin
               state_in = kmv_pkg::S_VCAP;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         kmv_pkg::S_VCAP: begin
            cmd.var_load = 1'b1;
            state_in     = kmv_pkg::S_FIN;
         end
         kmv_pkg::S_FIN: begin
            if (!st.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = kmv_pkg::S_IDLE;
            end
         end
         default: state_in = kmv_pkg::S_IDLE;
      endcase
   end

   // Divider is only stepped while iterations remain
   a_step_live: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !st.div_done)
      else $error("divider stepped after completion");
endmodule

// File: hw/rtl/kmv_dp.sv
// Datapath: key and statistics tables, shared divider, multiplier, result register.
// Depends on kmv_pkg and kmv_ram.
module kmv_dp #(
   parameter int unsigned ENTRIES = kmv_pkg::ENTRIES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  kmv_pkg::kmv_cmd_type               cmd,
   output kmv_pkg::kmv_stat_type              st,
   input  logic [kmv_pkg::KEY_W-1:0]          req_key,
   input  logic [kmv_pkg::VAL_W-1:0]          req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [kmv_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [kmv_pkg::CNT_W-1:0]          rsp_count,
   output logic [kmv_pkg::VAL_W-1:0]          rsp_mean,
   output logic [kmv_pkg::VAR_W-1:0]          rsp_variance,
   output logic [1:0]                         rsp_status
);
   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned UW = $clog2(ENTRIES + 1);
   localparam int unsigned CW = kmv_pkg::CNT_W;
   localparam int unsigned VW = kmv_pkg::VAL_W;
   localparam int unsigned DW = kmv_pkg::DEV_W;

   // Sample and statistics registers
   logic [kmv_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [VW-1:0]              val_ff, val_in;
   logic [UW-1:0]              idx_ff, idx_in, used_ff, used_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [VW-1:0]              mean_ff, mean_in;
   logic [DW-1:0]              dev_ff, dev_in;
   logic                       neg_ff, neg_in;
   logic [VW:0]                dmag_ff, dmag_in, amag_ff, amag_in;
   logic [VW+VW+1:0]           prod_ff, prod_in;
   logic [kmv_pkg::VAR_W-1:0]  var_ff, var_in;
   kmv_pkg::kmv_status_type    status_ff, status_in;
   // Divider registers
   logic [CW-1:0]              rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DW-1:0]              quo_ff, quo_in;
   logic [kmv_pkg::DIV_ITER_W-1:0] iter_ff, iter_in;
   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [kmv_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [CW-1:0]              rsp_count_ff, rsp_count_in;
   logic [VW-1:0]              rsp_mean_ff, rsp_mean_in;
   logic [kmv_pkg::VAR_W-1:0]  rsp_var_ff, rsp_var_in;
   kmv_pkg::kmv_status_type    rsp_status_ff, rsp_status_in;

   // Table ports
   logic [kmv_pkg::KEY_W-1:0]   krd_data;
   logic [kmv_pkg::STATS_W-1:0] srd_data;
   logic                        swe;

   // Arithmetic nets
   logic [VW:0]    delta;
   logic [VW:0]    dmag_c;
   logic [CW:0]    rtrial;
   logic           ge;
   logic [VW+1:0]  nmean;
   logic [VW+1:0]  vdiff;
   logic [VW-VW/2:0] mul_b;
   logic [VW+VW/2+1:0] pp;
   logic [DW:0]    dsum;

   kmv_ram #(.WIDTH(kmv_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock (clock),
      .we    (cmd.key_new),
      .waddr (used_ff[IW-1:0]),
      .wdata (key_ff),
      .raddr (idx_ff[IW-1:0]),
      .rdata (krd_data)
   );

   kmv_ram #(.WIDTH(kmv_pkg::STATS_W), .DEPTH(ENTRIES)) u_stats_ram (
      .clock (clock),
      .we    (swe),
      .waddr (idx_ff[IW-1:0]),
      .wdata ({cnt_ff, mean_ff, dev_ff}),
      .raddr (idx_ff[IW-1:0]),
      .rdata (srd_data)
   );

   // Arithmetic
   always_comb begin
      delta  = {val_ff[VW-1], val_ff} - {mean_ff[VW-1], mean_ff};
      dmag_c = delta[VW] ? (~delta + 1'b1) : delta;
      rtrial = {rem_ff, quo_ff[DW-1]};
      ge     = (rtrial >= {1'b0, dvs_ff});
      nmean  = neg_ff ? ({{2{mean_ff[VW-1]}}, mean_ff} - {1'b0, quo_ff[VW:0]})
                      : ({{2{mean_ff[VW-1]}}, mean_ff} + {1'b0, quo_ff[VW:0]});
      vdiff  = {{2{val_ff[VW-1]}}, val_ff} - {{2{mean_ff[VW-1]}}, mean_ff};
      mul_b  = cmd.mul_hi ? dmag_ff[VW:VW/2] : {1'b0, dmag_ff[VW/2-1:0]};
      pp     = amag_ff * mul_b;
      dsum   = {1'b0, dev_ff} + (DW+1)'(prod_ff[VW+VW+1:VW/2]);
   end

   // Status to the controller
   always_comb begin
      st.at_end    = (idx_ff == used_ff);
      st.full      = (used_ff == UW'(ENTRIES));
      st.key_match = (krd_data == key_ff);
      st.cnt_max   = (srd_data[kmv_pkg::STATS_W-1 -: CW] == kmv_pkg::CNT_MAX);
      st.cnt_le1   = (cnt_ff <= CW'(1));
      st.div_done  = (iter_ff == '0);
      st.out_busy  = rsp_valid_ff && !rsp_ready;
      swe          = cmd.var_start;
   end

   // Next values
   always_comb begin
      key_in = key_ff;   val_in = val_ff;   idx_in = idx_ff;   used_in = used_ff;
      cnt_in = cnt_ff;   mean_in = mean_ff; dev_in = dev_ff;   neg_in = neg_ff;
      dmag_in = dmag_ff; amag_in = amag_ff; prod_in = prod_ff; var_in = var_ff;
      status_in = status_ff;
      rem_in = rem_ff;   dvs_in = dvs_ff;   quo_in = quo_ff;   iter_in = iter_ff;
      rsp_slot_in = rsp_slot_ff;  rsp_count_in = rsp_count_ff;
      rsp_mean_in = rsp_mean_ff;  rsp_var_in = rsp_var_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.accept) begin
         key_in = req_key;
         val_in = req_value;
         idx_in = '0;
      end
      if (cmd.key_step) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.key_new) begin
         idx_in    = used_ff;
         used_in   = used_ff + 1'b1;
         cnt_in    = '0;
         mean_in   = '0;
         dev_in    = '0;
         status_in = kmv_pkg::ST_NEW_KEY;
      end
      if (cmd.key_full) begin
         idx_in    = '0;
         cnt_in    = '0;
         mean_in   = '0;
         var_in    = '0;
         status_in = kmv_pkg::ST_TABLE_FULL;
      end
      if (cmd.stat_load) begin
         {cnt_in, mean_in, dev_in} = srd_data;
         status_in = st.cnt_max ? kmv_pkg::ST_COUNT_SAT : kmv_pkg::ST_UPDATED;
      end
      // Mean step: |delta| / (count + 1)
      if (cmd.upd_start) begin
         cnt_in  = cnt_ff + 1'b1;
         dvs_in  = cnt_ff + 1'b1;
         neg_in  = delta[VW];
         dmag_in = dmag_c;
         rem_in  = '0;
         quo_in  = {dmag_c, {(DW-VW-1){1'b0}}};
         iter_in = kmv_pkg::MEAN_DIV_BITS;
      end
      // One restoring division bit per cycle
      if (cmd.div_step) begin
         rem_in  = ge ? CW'(rtrial - {1'b0, dvs_ff}) : rtrial[CW-1:0];
         quo_in  = {quo_ff[DW-2:0], ge};
         iter_in = iter_ff - 1'b1;
      end
      if (cmd.mean_upd) begin
         mean_in = nmean[VW-1:0];
      end
      if (cmd.amag) begin
         amag_in = vdiff[VW+1] ? (VW+1)'(~vdiff + 1'b1) : vdiff[VW:0];
      end
      // Product of the two deviations in two partial products
      if (cmd.mul_lo) begin
         prod_in = (VW+VW+2)'(pp);
      end
      if (cmd.mul_hi) begin
         prod_in = prod_ff + {pp, {(VW/2){1'b0}}};
      end
      if (cmd.acc) begin
         dev_in = dsum[DW] ? '1 : dsum[DW-1:0];
      end
      // Variance: deviation sum / (count - 1)
      if (cmd.var_start) begin
         if (cnt_ff <= CW'(1)) begin
            var_in = '0;
         end else begin
            rem_in  = '0;
            quo_in  = dev_ff;
            dvs_in  = cnt_ff - 1'b1;
            iter_in = kmv_pkg::VAR_DIV_BITS;
         end
      end
      if (cmd.var_load) begin
         var_in = (|quo_ff[DW-1:kmv_pkg::VAR_W]) ? '1 : quo_ff[kmv_pkg::VAR_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = kmv_pkg::SLOT_W'(idx_ff);
         rsp_count_in  = cnt_ff;
         rsp_mean_in   = mean_ff;
         rsp_var_in    = var_ff;
         rsp_status_in = status_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff  <= key_in;   val_ff  <= val_in;   idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;   mean_ff <= mean_in;  dev_ff  <= dev_in;
      neg_ff  <= neg_in;   dmag_ff <= dmag_in;  amag_ff <= amag_in;
      prod_ff <= prod_in;  var_ff  <= var_in;   status_ff <= status_in;
      rem_ff  <= rem_in;   dvs_ff  <= dvs_in;   quo_ff  <= quo_in;
      rsp_slot_ff  <= rsp_slot_in;   rsp_count_ff  <= rsp_count_in;
      rsp_mean_ff  <= rsp_mean_in;   rsp_var_ff    <= rsp_var_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_mean     = rsp_mean_ff;
   assign rsp_variance = rsp_var_ff;
   assign rsp_status   = rsp_status_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(ENTRIES))
      else $error("table fill count beyond depth");
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == kmv_pkg::ST_TABLE_FULL
      |-> rsp_count_ff == '0 && rsp_var_ff == '0 && rsp_slot_ff == '0)
      else $error("dropped transaction carries statistics");
   a_new_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == kmv_pkg::ST_NEW_KEY
      |-> rsp_count_ff == CW'(1) && rsp_var_ff == '0)
      else $error("new key result not a first sample");
   a_upd_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == kmv_pkg::ST_UPDATED |-> rsp_count_ff > CW'(1))
      else $error("updated key with count below two");
endmodule

// File: hw/rtl/keyed_running_mean_variance_unit.sv
// Keyed running mean / variance unit: top level.
// Depends on kmv_pkg, kmv_if, kmv_ram, kmv_ctrl, kmv_dp.
//
// Usage:
//   req: one transaction carries a key and a Q16.16 sample. The key is looked
//   up in insertion order; a new key takes the next free slot.
//   rsp: one transaction per request with slot, count, Q16.16 mean, Q32.16
//   sample variance and status (updated, new key, table full, count saturated).
//   Only one request is in flight; req.ready is high while the unit is idle.
//   Each slot searched is a key memory read, then a compare. A sample that
//   is added then goes through a 33-bit mean division and, once its count
//   exceeds one, a 64-bit variance division in the shared bit-serial
//   divider; a table-full drop searches all ENTRIES slots and skips both.
//   The result sits in an output register; a new request is taken while it
//   waits, and a stalled receiver only holds back the next result.
//   Reset clears the fill count, the controller and the result valid; the
//   tables need no clearing since only filled slots are ever read.
module keyed_running_mean_variance_unit #(
   parameter int unsigned ENTRIES = kmv_pkg::ENTRIES_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   kmv_req_if.sink   req_bus,
   kmv_rsp_if.source rsp_bus
);
   kmv_pkg::kmv_cmd_type  cmd;
   kmv_pkg::kmv_stat_type st;
   logic [1:0]            rsp_status;

   kmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .st        (st),
      .cmd       (cmd)
   );

   kmv_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .req_key      (req_bus.key),
      .req_value    (req_bus.sample_value),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_slot     (rsp_bus.slot),
      .rsp_count    (rsp_bus.sample_count),
      .rsp_mean     (rsp_bus.running_mean),
      .rsp_variance (rsp_bus.sample_variance),
      .rsp_status   (rsp_status)
   );

   assign rsp_bus.status = rsp_status;
endmodule

// File: verif/keyed_running_mean_variance_unit_tb.sv
// Testbench for the keyed running mean / variance unit: directed and random
// samples checked against a Welford predictor. Depends on kmv_pkg, kmv_if.
module keyed_running_mean_variance_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kmv_pkg::*;

   localparam int unsigned TABLE_DEPTH = 64;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned KEY_POOL    = 80;
   localparam logic [VAR_W-1:0] VAR_CEIL = '1;

   typedef struct {
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] value;
      bit                      drain;
   } sample_t;

   typedef struct {
      logic [SLOT_W-1:0]       slot;
      logic [CNT_W-1:0]        count;
      logic signed [VAL_W-1:0] mean;
      logic [VAR_W-1:0]        variance;
      kmv_status_type          status;
   } stats_t;

   logic clock;
   logic reset;
   kmv_req_if req_bus ();
   kmv_rsp_if rsp_bus ();

   keyed_running_mean_variance_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predictor state: one row per key slot
   logic [KEY_W-1:0] grp_key   [TABLE_DEPTH];
   logic [CNT_W-1:0] grp_count [TABLE_DEPTH];
   longint           grp_mean  [TABLE_DEPTH];
   bit [63:0]        grp_devsum[TABLE_DEPTH];
   int unsigned      grp_used;

   sample_t     sample_q[$];
   stats_t      stats_q[$];
   logic [KEY_W-1:0] key_pool[KEY_POOL];
   int unsigned errors;
   int unsigned cycles;
   int unsigned issued, taken, rsp_taken, rsp_handled;
   int unsigned status_seen[4];
   int unsigned req_gap, rsp_stall;
   bit          req_burst, rsp_burst, req_pending;

   function automatic bit [63:0] magnitude(longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   function automatic logic [VAR_W-1:0] variance_of(int unsigned s);
      bit [63:0] q;
      if (grp_count[s] <= 1) return '0;
      q = grp_devsum[s] / (64'(grp_count[s]) - 1);
      return (q > 64'(VAR_CEIL)) ? VAR_CEIL : q[VAR_W-1:0];
   endfunction

   // Welford step on one slot
   function automatic void welford_update(int unsigned s, longint v);
      longint    old_mean, delta, new_mean;
      bit [63:0] c, stepv, term, sum;
      old_mean = grp_mean[s];
      delta    = v - old_mean;
      c        = 64'(grp_count[s]) + 1;
      stepv    = magnitude(delta) / c;
      new_mean = (delta < 0) ? old_mean - longint'(stepv) : old_mean + longint'(stepv);
      term     = (magnitude(v - new_mean) * magnitude(v - old_mean)) >> 16;
      sum      = grp_devsum[s] + term;
      if (sum < term) sum = '1;
      grp_count[s]  = c[CNT_W-1:0];
      grp_mean[s]   = new_mean;
      grp_devsum[s] = sum;
   endfunction

   function automatic stats_t predict_stats(logic [KEY_W-1:0] key, logic signed [VAL_W-1:0] val);
      stats_t r;
      int unsigned s;
      bit found;
      s = 0;
      found = 0;
      while (s < grp_used) begin
         if (grp_key[s] == key) begin
            found = 1;
            break;
         end
         s++;
      end
      if (found) begin
         if (grp_count[s] == CNT_MAX) r.status = ST_COUNT_SAT;
         else begin
            welford_update(s, longint'(val));
            r.status = ST_UPDATED;
         end
      end else if (grp_used >= TABLE_DEPTH) begin
         r.slot = '0; r.count = '0; r.mean = '0; r.variance = '0;
         r.status = ST_TABLE_FULL;
         return r;
      end else begin
         s = grp_used;
         grp_key[s] = key; grp_count[s] = '0; grp_mean[s] = 0; grp_devsum[s] = '0;
         grp_used++;
         welford_update(s, longint'(val));
         r.status = ST_NEW_KEY;
      end
      r.slot     = s[SLOT_W-1:0];
      r.count    = grp_count[s];
      r.mean     = grp_mean[s][VAL_W-1:0];
      r.variance = variance_of(s);
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] random_value();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         1, 2:    return $signed(32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000);
         default: return $signed($urandom());
      endcase
   endfunction

   // Clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout at %0t with %0d results outstanding", $time, stats_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Request acceptance: predict the result of each taken transaction
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         stats_q.insert(stats_q.size(), predict_stats(req_bus.key, req_bus.sample_value));
         taken++;
      end
   end

   // Driver: presents queued samples at the falling edge with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_pending && taken == issued) begin
            req_pending = 0;
            if ($urandom_range(0, 29) == 0) req_burst = ~req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 13);
         end
         if (!req_pending) begin
            if (req_gap > 0) req_gap--;
            else if (sample_q.size() > 0 && !(sample_q[0].drain && stats_q.size() != 0)) begin
               req_bus.key          <= sample_q[0].key;
               req_bus.sample_value <= sample_q[0].value;
               void'(sample_q.pop_front());
               req_pending = 1;
               issued++;
            end
         end
         req_bus.valid <= req_pending;
      end
   end

   // Result receiver: random stalls between transactions
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_handled != rsp_taken) begin
            rsp_handled = rsp_taken;
            if ($urandom_range(0, 29) == 0) rsp_burst = ~rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 13);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      stats_t e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_taken++;
         status_seen[rsp_bus.status]++;
         if (stats_q.size() == 0) begin
            $display("%0t: unexpected result, slot %0d status %0d", $time,
                     rsp_bus.slot, rsp_bus.status);
            errors++;
         end else begin
            e = stats_q.pop_front();
            if (rsp_bus.slot !== e.slot) begin
               $display("%0t: slot exp %0d got %0d", $time, e.slot, rsp_bus.slot);
               errors++;
            end
            if (rsp_bus.sample_count !== e.count) begin
               $display("%0t: count exp %0d got %0d", $time, e.count, rsp_bus.sample_count);
               errors++;
            end
            if (rsp_bus.running_mean !== e.mean) begin
               $display("%0t: mean exp %h got %h", $time, e.mean, rsp_bus.running_mean);
               errors++;
            end
            if (rsp_bus.sample_variance !== e.variance) begin
               $display("%0t: variance exp %h got %h", $time, e.variance,
                        rsp_bus.sample_variance);
               errors++;
            end
            if (rsp_bus.status !== e.status) begin
               $display("%0t: status exp %s got %0d", $time, e.status.name(), rsp_bus.status);
               errors++;
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      sample_t it;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.key          = '0;
      req_bus.sample_value = '0;
      rsp_bus.ready        = 1'b0;
      grp_used = 0;
      req_burst = 0; rsp_burst = 0; req_pending = 0;
      req_gap = 0; rsp_stall = 0;

      // Directed: key extremes, value extremes, repeats on several keys
      it.drain = 0;
      foreach (key_pool[i]) key_pool[i] = $urandom();
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 0; i < 4; i++) begin
         it.key = '0; it.value = i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         sample_q.insert(sample_q.size(), it);
         it.key = '1; it.value = i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         sample_q.insert(sample_q.size(), it);
      end
      foreach (key_pool[i]) if (i >= 2 && i < 6) begin
         it.key = key_pool[i]; it.value = 32'sh0001_0000;
         sample_q.insert(sample_q.size(), it);
         it.value = -32'sh0001_0000;
         sample_q.insert(sample_q.size(), it);
         it.value = 32'sh0000_0001;
         sample_q.insert(sample_q.size(), it);
      end
      it.key = key_pool[2]; it.value = 0;
      sample_q.insert(sample_q.size(), it);

      // Random: mostly a working set of keys, overflowing the table later on
      for (int i = 0; i < 450; i++) begin
         it.drain = (i == 200);
         if ($urandom_range(0, 9) < 7) it.key = key_pool[$urandom_range(0, 47)];
         else if ($urandom_range(0, 9) == 0) it.key = $urandom();
         else it.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
         it.value = random_value();
         sample_q.insert(sample_q.size(), it);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (sample_q.size() == 0 && !req_pending && stats_q.size() == 0);
      repeat (300) @(posedge clock);
      $display("Sent %0d samples over %0d table slots; results: %0d updates, %0d new keys,",
               taken, grp_used, status_seen[ST_UPDATED], status_seen[ST_NEW_KEY]);
      $display("%0d table-full drops, %0d count-saturated drops.",
               status_seen[ST_TABLE_FULL], status_seen[ST_COUNT_SAT]);
      if (errors == 0 && stats_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
